// ----- rtl/kte_pkg.sv -----
// ----------------------------------------------------------------------------
// kte_pkg
// Types, constants and the micro-op program of the tilt angle estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package kte_pkg;

  localparam int DATA_W        = 32;
  localparam int CFG_W         = 31;
  localparam int FRAC_BITS_DEF = 20;
  localparam int CFG_IDX_W     = 3;
  localparam int NUM_UOPS      = 32;
  localparam int STEP_W        = $clog2(NUM_UOPS);

  localparam logic [CFG_W-1:0] TIME_STEP_RST   = CFG_W'(5243);
  localparam logic [CFG_W-1:0] ANGLE_NOISE_RST = CFG_W'(1049);
  localparam logic [CFG_W-1:0] BIAS_NOISE_RST  = CFG_W'(3146);
  localparam logic [CFG_W-1:0] MEAS_NOISE_RST  = CFG_W'(524288);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP   = 3'd0,
    CFG_ANGLE_NOISE = 3'd1,
    CFG_BIAS_NOISE  = 3'd2,
    CFG_MEAS_NOISE  = 3'd3,
    CFG_OBS_GAIN    = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_WB,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_SUB2,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef enum logic [4:0] {
    SRC_ZERO,
    SRC_ANGLE,
    SRC_BIAS,
    SRC_P00,
    SRC_P01,
    SRC_P10,
    SRC_P11,
    SRC_ERR,
    SRC_D0,
    SRC_D1,
    SRC_CP00,
    SRC_CP01,
    SRC_E,
    SRC_K0,
    SRC_K1,
    SRC_TMP,
    SRC_MEAS,
    SRC_RATE,
    SRC_DT,
    SRC_QA,
    SRC_QG,
    SRC_R,
    SRC_C
  } src_e;

  typedef struct packed {
    op_e  op;
    src_e a;
    src_e b;
    src_e c;
    src_e dst;
  } uop_t;

  typedef struct packed {
    logic en;
    op_e  op;
  } alu_ctrl_t;

  function automatic uop_t mk_uop(input op_e op, input src_e a, input src_e b,
                                  input src_e c, input src_e dst);
    uop_t u;
    u.op  = op;
    u.a   = a;
    u.b   = b;
    u.c   = c;
    u.dst = dst;
    return u;
  endfunction

  function automatic uop_t uop_at(input logic [STEP_W-1:0] step);
    uop_t u;
    unique case (step)
      // predict angle
      5'd0:  u = mk_uop(OP_SUB,  SRC_RATE,  SRC_BIAS,  SRC_ZERO, SRC_TMP);
      5'd1:  u = mk_uop(OP_MUL,  SRC_TMP,   SRC_DT,    SRC_ZERO, SRC_TMP);
      5'd2:  u = mk_uop(OP_ADD,  SRC_ANGLE, SRC_TMP,   SRC_ZERO, SRC_ANGLE);
      5'd3:  u = mk_uop(OP_SUB,  SRC_MEAS,  SRC_ANGLE, SRC_ZERO, SRC_ERR);
      // propagate covariance
      5'd4:  u = mk_uop(OP_SUB2, SRC_QA,    SRC_P01,   SRC_P10,  SRC_D0);
      5'd5:  u = mk_uop(OP_SUB,  SRC_ZERO,  SRC_P11,   SRC_ZERO, SRC_D1);
      5'd6:  u = mk_uop(OP_MUL,  SRC_D0,    SRC_DT,    SRC_ZERO, SRC_TMP);
      5'd7:  u = mk_uop(OP_ADD,  SRC_P00,   SRC_TMP,   SRC_ZERO, SRC_P00);
      5'd8:  u = mk_uop(OP_MUL,  SRC_D1,    SRC_DT,    SRC_ZERO, SRC_TMP);
      5'd9:  u = mk_uop(OP_ADD,  SRC_P01,   SRC_TMP,   SRC_ZERO, SRC_P01);
      5'd10: u = mk_uop(OP_ADD,  SRC_P10,   SRC_TMP,   SRC_ZERO, SRC_P10);
      5'd11: u = mk_uop(OP_MUL,  SRC_QG,    SRC_DT,    SRC_ZERO, SRC_TMP);
      5'd12: u = mk_uop(OP_ADD,  SRC_P11,   SRC_TMP,   SRC_ZERO, SRC_P11);
      // innovation variance and gains
      5'd13: u = mk_uop(OP_MUL,  SRC_C,     SRC_P00,   SRC_ZERO, SRC_CP00);
      5'd14: u = mk_uop(OP_MUL,  SRC_C,     SRC_P01,   SRC_ZERO, SRC_CP01);
      5'd15: u = mk_uop(OP_MUL,  SRC_C,     SRC_CP00,  SRC_ZERO, SRC_TMP);
      5'd16: u = mk_uop(OP_ADD,  SRC_R,     SRC_TMP,   SRC_ZERO, SRC_E);
      5'd17: u = mk_uop(OP_DIV,  SRC_CP00,  SRC_E,     SRC_ZERO, SRC_K0);
      5'd18: u = mk_uop(OP_MUL,  SRC_C,     SRC_P10,   SRC_ZERO, SRC_TMP);
      5'd19: u = mk_uop(OP_DIV,  SRC_TMP,   SRC_E,     SRC_ZERO, SRC_K1);
      // covariance update
      5'd20: u = mk_uop(OP_MUL,  SRC_K0,    SRC_CP00,  SRC_ZERO, SRC_TMP);
      5'd21: u = mk_uop(OP_SUB,  SRC_P00,   SRC_TMP,   SRC_ZERO, SRC_P00);
      5'd22: u = mk_uop(OP_MUL,  SRC_K0,    SRC_CP01,  SRC_ZERO, SRC_TMP);
      5'd23: u = mk_uop(OP_SUB,  SRC_P01,   SRC_TMP,   SRC_ZERO, SRC_P01);
      5'd24: u = mk_uop(OP_MUL,  SRC_K1,    SRC_CP00,  SRC_ZERO, SRC_TMP);
      5'd25: u = mk_uop(OP_SUB,  SRC_P10,   SRC_TMP,   SRC_ZERO, SRC_P10);
      5'd26: u = mk_uop(OP_MUL,  SRC_K1,    SRC_CP01,  SRC_ZERO, SRC_TMP);
      5'd27: u = mk_uop(OP_SUB,  SRC_P11,   SRC_TMP,   SRC_ZERO, SRC_P11);
      // state correction
      5'd28: u = mk_uop(OP_MUL,  SRC_K0,    SRC_ERR,   SRC_ZERO, SRC_TMP);
      5'd29: u = mk_uop(OP_ADD,  SRC_ANGLE, SRC_TMP,   SRC_ZERO, SRC_ANGLE);
      5'd30: u = mk_uop(OP_MUL,  SRC_K1,    SRC_ERR,   SRC_ZERO, SRC_TMP);
      5'd31: u = mk_uop(OP_ADD,  SRC_BIAS,  SRC_TMP,   SRC_ZERO, SRC_BIAS);
      default: u = mk_uop(OP_ADD, SRC_ZERO, SRC_ZERO,  SRC_ZERO, SRC_ZERO);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/kte_if.sv -----
// ----------------------------------------------------------------------------
// kte_if
// Valid/ready channels for sample pairs and estimate results.
// ----------------------------------------------------------------------------
`default_nettype none

interface kte_in_if import kte_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sensed_angle;
  logic signed [DATA_W-1:0] sensed_rate;

  modport source (output valid, output sensed_angle, output sensed_rate, input ready);
  modport sink   (input valid, input sensed_angle, input sensed_rate, output ready);
endinterface

interface kte_out_if import kte_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] angle_estimate;
  logic signed [DATA_W-1:0] bias_estimate;

  modport source (output valid, output angle_estimate, output bias_estimate, input ready);
  modport sink   (input valid, input angle_estimate, input bias_estimate, output ready);
endinterface

`default_nettype wire

// ----- rtl/kte_alu.sv -----
// ----------------------------------------------------------------------------
// kte_alu
// Shared multiply / add / subtract unit with registered raw result,
// fixed point scaling and saturation to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module kte_alu import kte_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire                            clk_i,
  input  wire alu_ctrl_t                 ctrl_i,
  input  wire logic signed [DATA_W-1:0]  a_i,
  input  wire logic signed [DATA_W-1:0]  b_i,
  input  wire logic signed [DATA_W-1:0]  c_i,
  output logic signed [DATA_W-1:0]       res_o
);

  localparam int WIDE_W = 2 * DATA_W;

  logic signed [WIDE_W-1:0] raw_d, raw_q;
  logic                     mul_q;
  logic signed [WIDE_W-1:0] scaled;
  logic signed [WIDE_W-1:0] a_w, b_w, c_w;

  always_comb begin
    a_w = WIDE_W'(a_i);
    b_w = WIDE_W'(b_i);
    c_w = WIDE_W'(c_i);
    case (ctrl_i.op)
      OP_MUL:  raw_d = a_w * b_w;
      OP_SUB:  raw_d = a_w - b_w;
      OP_SUB2: raw_d = a_w - b_w - c_w;
      default: raw_d = a_w + b_w;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      raw_q <= raw_d;
      mul_q <= (ctrl_i.op == OP_MUL);
    end
  end

  // floor shift for products, then clamp to the signed 32 bit range
  always_comb begin
    scaled = mul_q ? (raw_q >>> FRAC_BITS) : raw_q;
    if ((&scaled[WIDE_W-1:DATA_W-1]) || !(|scaled[WIDE_W-1:DATA_W-1])) begin
      res_o = scaled[DATA_W-1:0];
    end else if (scaled[WIDE_W-1]) begin
      res_o = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/kte_div.sv -----
// ----------------------------------------------------------------------------
// kte_div
// Radix-2 restoring divider: (num << FRAC_BITS) / den, truncated toward
// zero and saturated; a zero divisor gives zero.
// ----------------------------------------------------------------------------
`default_nettype none

module kte_div import kte_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start_i,
  input  wire logic signed [DATA_W-1:0]  num_i,
  input  wire logic signed [DATA_W-1:0]  den_i,
  output logic                           done_o,
  output logic signed [DATA_W-1:0]       quo_o
);

  localparam int NUM_W = DATA_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [NUM_W-1:0]  dvd_q;
  logic [DATA_W-1:0] rem_q, den_q;
  logic              neg_q, zero_q;

  logic [DATA_W-1:0] num_mag, den_mag;
  logic [DATA_W:0]   rem_sh, rem_sub;
  logic              ge;
  logic [NUM_W-DATA_W:0] hi;
  logic [DATA_W-2:0] lo;

  always_comb begin
    num_mag = num_i[DATA_W-1] ? (~num_i + DATA_W'(1)) : num_i;
    den_mag = den_i[DATA_W-1] ? (~den_i + DATA_W'(1)) : den_i;
    rem_sh  = {rem_q, dvd_q[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    ge      = (rem_sh >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= {num_mag, {FRAC_BITS{1'b0}}};
      rem_q  <= '0;
      den_q  <= den_mag;
      neg_q  <= num_i[DATA_W-1] ^ den_i[DATA_W-1];
      zero_q <= (den_i == '0);
    end else if (busy_q) begin
      dvd_q <= {dvd_q[NUM_W-2:0], ge};
      rem_q <= ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
    end
  end

  always_comb begin
    hi = dvd_q[NUM_W-1:DATA_W-1];
    lo = dvd_q[DATA_W-2:0];
    if (zero_q) begin
      quo_o = '0;
    end else if (neg_q) begin
      quo_o = (hi != '0) ? {1'b1, {(DATA_W-1){1'b0}}} : -$signed({1'b0, lo});
    end else begin
      quo_o = (hi != '0) ? {1'b0, {(DATA_W-1){1'b1}}} : $signed({1'b0, lo});
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

// ----- rtl/kalman_tilt_angle_estimator.sv -----
// sequence: 30 micro-ops on the shared ALU plus two divider runs per sample;
// a new sample is taken only in idle, after the result has been loaded
// into the output register, which can stall on a full output; the shared
// multiplier and the radix-2 divider carry all arithmetic under one sequencer
// reset: asynchronous, active low; clears angle, bias and covariance and
// loads the default noise, time step and observation gain
// ----------------------------------------------------------------------------
// kalman_tilt_angle_estimator
// Two-state Kalman filter fusing an accelerometer angle with a gyro rate.
// ----------------------------------------------------------------------------
`default_nettype none

module kalman_tilt_angle_estimator import kte_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  kte_in_if.sink               in_if,
  kte_out_if.source            out_if,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [DATA_W-1:0]     cfg_data_i
);

  localparam logic signed [DATA_W-1:0] OBS_GAIN_RST = DATA_W'(64'd1 << FRAC_BITS);

  state_e                   state_q, state_d;
  logic [STEP_W-1:0]        step_q, step_d;
  uop_t                     uop;
  alu_ctrl_t                alu_ctrl;
  logic                     div_start, div_done, wb_en, out_load;
  logic signed [DATA_W-1:0] opa, opb, opc, alu_res, div_res, wb_val;

  logic [CFG_W-1:0]         dt_q, qa_q, qg_q, r_q;
  logic signed [DATA_W-1:0] c_q;
  logic signed [DATA_W-1:0] angle_q, bias_q, p00_q, p01_q, p10_q, p11_q;
  logic signed [DATA_W-1:0] err_q, d0_q, d1_q, cp00_q, cp01_q, e_q, k0_q, k1_q, tmp_q;
  logic signed [DATA_W-1:0] meas_q, rate_q;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] angle_out_q, bias_out_q;

  function automatic logic signed [DATA_W-1:0] opnd(input src_e s);
    logic signed [DATA_W-1:0] v;
    unique case (s)
      SRC_ANGLE: v = angle_q;
      SRC_BIAS:  v = bias_q;
      SRC_P00:   v = p00_q;
      SRC_P01:   v = p01_q;
      SRC_P10:   v = p10_q;
      SRC_P11:   v = p11_q;
      SRC_ERR:   v = err_q;
      SRC_D0:    v = d0_q;
      SRC_D1:    v = d1_q;
      SRC_CP00:  v = cp00_q;
      SRC_CP01:  v = cp01_q;
      SRC_E:     v = e_q;
      SRC_K0:    v = k0_q;
      SRC_K1:    v = k1_q;
      SRC_TMP:   v = tmp_q;
      SRC_MEAS:  v = meas_q;
      SRC_RATE:  v = rate_q;
      SRC_DT:    v = {1'b0, dt_q};
      SRC_QA:    v = {1'b0, qa_q};
      SRC_QG:    v = {1'b0, qg_q};
      SRC_R:     v = {1'b0, r_q};
      SRC_C:     v = c_q;
      default:   v = '0;
    endcase
    return v;
  endfunction

  assign uop = uop_at(step_q);

  always_comb begin
    opa = opnd(uop.a);
    opb = opnd(uop.b);
    opc = opnd(uop.c);
  end

  kte_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk_i  (clk_i),
    .ctrl_i (alu_ctrl),
    .a_i    (opa),
    .b_i    (opb),
    .c_i    (opc),
    .res_o  (alu_res)
  );

  kte_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (opa),
    .den_i   (opb),
    .done_o  (div_done),
    .quo_o   (div_res)
  );

  assign wb_val = (uop.op == OP_DIV) ? div_res : alu_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    alu_ctrl.en = 1'b0;
    alu_ctrl.op = uop.op;
    div_start   = 1'b0;
    wb_en       = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_if.valid) begin
          state_d = ST_EXEC;
          step_d  = '0;
        end
      end
      ST_EXEC: begin
        if (uop.op == OP_DIV) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          alu_ctrl.en = 1'b1;
          state_d     = ST_WB;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        wb_en = 1'b1;
        if (step_q == STEP_W'(NUM_UOPS - 1)) begin
          state_d = ST_DONE;
        end else begin
          step_d  = step_q + STEP_W'(1);
          state_d = ST_EXEC;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_if.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_if.ready = (state_q == ST_IDLE);

  // configuration and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q    <= TIME_STEP_RST;
      qa_q    <= ANGLE_NOISE_RST;
      qg_q    <= BIAS_NOISE_RST;
      r_q     <= MEAS_NOISE_RST;
      c_q     <= OBS_GAIN_RST;
      angle_q <= '0;
      bias_q  <= '0;
      p00_q   <= '0;
      p01_q   <= '0;
      p10_q   <= '0;
      p11_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TIME_STEP:   dt_q <= cfg_data_i[CFG_W-1:0];
          CFG_ANGLE_NOISE: qa_q <= cfg_data_i[CFG_W-1:0];
          CFG_BIAS_NOISE:  qg_q <= cfg_data_i[CFG_W-1:0];
          CFG_MEAS_NOISE:  r_q  <= cfg_data_i[CFG_W-1:0];
          CFG_OBS_GAIN:    c_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (wb_en) begin
        case (uop.dst)
          SRC_ANGLE: angle_q <= wb_val;
          SRC_BIAS:  bias_q  <= wb_val;
          SRC_P00:   p00_q   <= wb_val;
          SRC_P01:   p01_q   <= wb_val;
          SRC_P10:   p10_q   <= wb_val;
          SRC_P11:   p11_q   <= wb_val;
          default: ;
        endcase
      end
    end
  end

  // scratch values of one sample
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      meas_q <= in_if.sensed_angle;
      rate_q <= in_if.sensed_rate;
    end
    if (wb_en) begin
      case (uop.dst)
        SRC_ERR:  err_q  <= wb_val;
        SRC_D0:   d0_q   <= wb_val;
        SRC_D1:   d1_q   <= wb_val;
        SRC_CP00: cp00_q <= wb_val;
        SRC_CP01: cp01_q <= wb_val;
        SRC_E:    e_q    <= wb_val;
        SRC_K0:   k0_q   <= wb_val;
        SRC_K1:   k1_q   <= wb_val;
        SRC_TMP:  tmp_q  <= wb_val;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      angle_out_q <= angle_q;
      bias_out_q  <= bias_q;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.angle_estimate = angle_out_q;
  assign out_if.bias_estimate  = bias_out_q;

endmodule

`default_nettype wire

// ----- rtl/kte_checker.sv -----
// ----------------------------------------------------------------------------
// kte_checker
// Port-level checks of the tilt angle estimator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kte_checker import kte_pkg::*; (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_ready_i,
  input wire                out_valid_i,
  input wire                out_ready_i,
  input wire [DATA_W-1:0]   angle_i,
  input wire [DATA_W-1:0]   bias_i
);

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(angle_i) && $stable(bias_i))
    else $error("result changed while stalled");

  // one sample at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready while a sample is in progress");

  // a fresh result frees the input side
  a_ready_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("not ready after producing a result");

endmodule

bind kalman_tilt_angle_estimator kte_checker u_kte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .angle_i     (out_if.angle_estimate),
  .bias_i      (out_if.bias_estimate)
);

`default_nettype wire

// ----- bench/kalman_tilt_angle_estimator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kalman_tilt_angle_estimator_tb
// Drives sample pairs through the tilt angle estimator under random idling
// on both channels and checks every angle and bias estimate against a
// fixed-point filter model held in a scoreboard. Runs a few directed
// extremes first, then random phases under several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module kalman_tilt_angle_estimator_tb;
  import kte_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 150;

  typedef logic signed [DATA_W-1:0] fix_t;

  typedef struct {
    fix_t angle;
    fix_t bias;
  } estimate_t;

  localparam fix_t FIX_MAX = 32'sh7fffffff;
  localparam fix_t FIX_MIN = 32'sh80000000;
  localparam fix_t FIX_ONE = 32'sh00100000;

  class tilt_scoreboard;
    fix_t time_step, angle_noise, bias_noise, meas_noise, obs_gain;
    fix_t angle_st, bias_st;
    fix_t cov[4];
    estimate_t estimate_q[$];
    int mismatches;

    function new();
      time_step   = {1'b0, TIME_STEP_RST};
      angle_noise = {1'b0, ANGLE_NOISE_RST};
      bias_noise  = {1'b0, BIAS_NOISE_RST};
      meas_noise  = {1'b0, MEAS_NOISE_RST};
      obs_gain    = fix_t'(1) <<< FRAC;
      angle_st    = '0;
      bias_st     = '0;
      foreach (cov[i]) cov[i] = '0;
      mismatches  = 0;
    endfunction

    function fix_t clamp(longint v);
      if (v > longint'(FIX_MAX)) return FIX_MAX;
      if (v < longint'(FIX_MIN)) return FIX_MIN;
      return fix_t'(v);
    endfunction

    // product shifted down with rounding toward minus infinity
    function fix_t qmul(fix_t a, fix_t b);
      longint p;
      p = longint'(a) * longint'(b);
      return clamp(p >>> FRAC);
    endfunction

    function fix_t qdiv(fix_t num, fix_t den);
      longint n;
      if (den == 0) return '0;
      n = longint'(num) <<< FRAC;
      return clamp(n / longint'(den));
    endfunction

    function fix_t qadd(fix_t a, fix_t b);
      return clamp(longint'(a) + longint'(b));
    endfunction

    function fix_t qsub(fix_t a, fix_t b);
      return clamp(longint'(a) - longint'(b));
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        CFG_TIME_STEP:   time_step   = {1'b0, data[CFG_W-1:0]};
        CFG_ANGLE_NOISE: angle_noise = {1'b0, data[CFG_W-1:0]};
        CFG_BIAS_NOISE:  bias_noise  = {1'b0, data[CFG_W-1:0]};
        CFG_MEAS_NOISE:  meas_noise  = {1'b0, data[CFG_W-1:0]};
        CFG_OBS_GAIN:    obs_gain    = data;
        default: ;
      endcase
    endfunction

    function void advance_filter(fix_t meas, fix_t rate);
      fix_t p00, p01, p10, p11, err, d0, d1, cp00, cp01, e, k0, k1;
      estimate_t est;
      p00 = cov[0];
      p01 = cov[1];
      p10 = cov[2];
      p11 = cov[3];

      angle_st = qadd(angle_st, qmul(qsub(rate, bias_st), time_step));
      err = qsub(meas, angle_st);

      d0 = clamp(longint'(angle_noise) - longint'(p01) - longint'(p10));
      d1 = clamp(-longint'(p11));
      p00 = qadd(p00, qmul(d0, time_step));
      p01 = qadd(p01, qmul(d1, time_step));
      p10 = qadd(p10, qmul(d1, time_step));
      p11 = qadd(p11, qmul(bias_noise, time_step));

      cp00 = qmul(obs_gain, p00);
      cp01 = qmul(obs_gain, p01);
      e = qadd(meas_noise, qmul(obs_gain, cp00));
      k0 = qdiv(cp00, e);
      k1 = qdiv(qmul(obs_gain, p10), e);

      p00 = qsub(p00, qmul(k0, cp00));
      p01 = qsub(p01, qmul(k0, cp01));
      p10 = qsub(p10, qmul(k1, cp00));
      p11 = qsub(p11, qmul(k1, cp01));
      cov[0] = p00;
      cov[1] = p01;
      cov[2] = p10;
      cov[3] = p11;

      angle_st = qadd(angle_st, qmul(k0, err));
      bias_st  = qadd(bias_st, qmul(k1, err));

      est.angle = angle_st;
      est.bias  = bias_st;
      estimate_q.push_back(est);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_estimate(fix_t angle, fix_t bias);
      estimate_t est;
      if (estimate_q.size() == 0) begin
        report_mismatch($sformatf("unexpected estimate angle %0d bias %0d", angle, bias));
      end else begin
        est = estimate_q.pop_front();
        if (angle !== est.angle)
          report_mismatch($sformatf("angle got %0d expected %0d", angle, est.angle));
        if (bias !== est.bias)
          report_mismatch($sformatf("bias got %0d expected %0d", bias, est.bias));
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0]    cfg_data_i;

  kte_in_if  in_ch ();
  kte_out_if out_ch ();

  tilt_scoreboard sb;
  bit             no_idle;
  int             hold_left;

  kalman_tilt_angle_estimator #(
    .FRAC_BITS(FRAC)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 30);
    return $urandom_range(50, 250);
  endfunction

  task automatic send_sample(input fix_t meas, input fix_t rate);
    int gap;
    in_ch.valid        <= 1'b1;
    in_ch.sensed_angle <= meas;
    in_ch.sensed_rate  <= rate;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    sb.advance_filter(meas, rate);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.estimate_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic put_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_register(idx, data);
  endtask

  // the unused top bit of the 31 bit registers is set at random
  task automatic program_filter(input logic [CFG_W-1:0] dt, input logic [CFG_W-1:0] qa,
                                input logic [CFG_W-1:0] qg, input logic [CFG_W-1:0] r,
                                input logic [DATA_W-1:0] c);
    put_register(CFG_TIME_STEP, {1'($urandom), dt});
    put_register(CFG_ANGLE_NOISE, {1'($urandom), qa});
    put_register(CFG_BIAS_NOISE, {1'($urandom), qg});
    put_register(CFG_MEAS_NOISE, {1'($urandom), r});
    put_register(CFG_OBS_GAIN, c);
    put_register(CFG_IDX_W'(CFG_OBS_GAIN) + CFG_IDX_W'($urandom_range(1, 3)), $urandom);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] edge_value();
    case ($urandom_range(0, 2))
      0: return '0;
      1: return '1;
      default: return CFG_W'($urandom_range(0, 64));
    endcase
  endfunction

  // receiving side with random stalls and a requested long hold-off
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        sb.check_estimate(out_ch.angle_estimate, out_ch.bias_estimate);
        stall_left = pick_gap();
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    fix_t dir_angle[10];
    fix_t dir_rate[10];
    fix_t meas, rate;
    int walk, drift;
    logic [DATA_W-1:0] gain;

    in_ch.valid        = 1'b0;
    in_ch.sensed_angle = '0;
    in_ch.sensed_rate  = '0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_TIME_STEP;
    cfg_data_i         = '0;
    rst_ni             = 1'b0;
    no_idle            = 1'b0;
    hold_left          = 0;
    sb = new();

    dir_angle = '{32'sd0, FIX_MAX, FIX_MIN, 32'sd0, 32'sd0, -32'sd1, FIX_ONE, FIX_MAX,
                  FIX_MIN, FIX_MIN};
    dir_rate  = '{32'sd0, 32'sd0, 32'sd0, FIX_MAX, FIX_MIN, -32'sd1, FIX_ONE, FIX_MAX,
                  FIX_MIN, FIX_MAX};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes under the reset settings
    foreach (dir_angle[i]) send_sample(dir_angle[i], dir_rate[i]);
    wait_drained();

    // zero innovation variance: both gains vanish
    program_filter(TIME_STEP_RST, ANGLE_NOISE_RST, BIAS_NOISE_RST, '0, '0);
    repeat (4) send_sample($urandom_range(0, 1 << 21), $urandom_range(0, 1 << 18));
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        4: program_filter($urandom, $urandom, $urandom, $urandom, $urandom);
        5, 6: begin
          case ($urandom_range(0, 3))
            0: gain = FIX_MIN;
            1: gain = FIX_MAX;
            2: gain = '0;
            default: gain = -FIX_ONE;
          endcase
          program_filter(edge_value(), edge_value(), edge_value(), edge_value(), gain);
        end
        PHASES - 1: program_filter(TIME_STEP_RST, ANGLE_NOISE_RST, BIAS_NOISE_RST,
                                   MEAS_NOISE_RST, FIX_ONE);
        default: begin
          gain = FIX_ONE + int'($urandom_range(0, 1 << 18)) - (1 << 17);
          if (ph == 3) gain = -gain;
          program_filter($urandom_range(1000, 20000), $urandom_range(0, 5000),
                         $urandom_range(0, 10000), $urandom_range(1 << 16, 1 << 21), gain);
        end
      endcase

      if (ph == 0) hold_left = 900;
      no_idle = (ph == 1);
      walk  = 0;
      drift = int'($urandom_range(0, 1 << 20)) - (1 << 19);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          meas = $urandom;
          rate = $urandom;
        end else begin
          if ($urandom_range(0, 30) == 0)
            walk = int'($urandom_range(0, 1 << 23)) - (1 << 22);
          walk = walk + int'($urandom_range(0, 4000)) - 2000;
          if (walk > (1 << 22)) walk = 1 << 22;
          if (walk < -(1 << 22)) walk = -(1 << 22);
          meas = walk + int'($urandom_range(0, 20000)) - 10000;
          rate = drift + int'($urandom_range(0, 8000)) - 4000;
        end
        send_sample(meas, rate);
      end
      wait_drained();
      no_idle = 1'b0;
    end

    repeat (400) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.estimate_q.size() == 0) begin
      $display("kalman_tilt_angle_estimator_tb OK");
    end else begin
      $display("kalman_tilt_angle_estimator_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("timeout with %0d estimates outstanding", sb.estimate_q.size());
    $display("kalman_tilt_angle_estimator_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
